// ----- rtl/core/bfdt_pkg.sv -----
// bfdt_pkg: shared types, constants and lookup functions for the leading-digit test
// used by benford_first_digit_test; no dependencies
`timescale 1ns / 1ps

package bfdt_pkg;

  // counter width default and digit store geometry
  localparam int COUNT_BITS_DEF = 24;
  localparam int DIGITS         = 10;
  localparam int DIG_W          = 4;

  // field widths
  localparam int VAL_W   = 31;
  localparam int DEV_W   = 22;
  localparam int STR_W   = 3;
  localparam int TOT_W   = 24;
  localparam int LIM_W   = 34;
  localparam int RECIP_W = 21;
  localparam int QW      = 22;
  localparam int ERR_W   = 21;
  localparam int SQ_W    = 2 * ERR_W;
  localparam int SUM_W   = SQ_W + 4;
  localparam int SHR_W   = SUM_W - 16;

  // fixed-point constants
  localparam logic [QW-1:0]    ONE_Q16     = QW'(65536);
  localparam logic [DEV_W-1:0] DEV_MAX     = DEV_W'(4194303);
  localparam logic [32:0]      TOTAL_MAX   = 33'(16777215);
  localparam logic [SHR_W-1:0] DEV_SAT_LIM = SHR_W'(37748736);

  // division by 9 as a reciprocal multiply, exact for dividends below 2^27
  localparam int              D9_W     = 26;
  localparam int              D9_PW    = 2 * D9_W;
  localparam int              DIV9_SH  = 29;
  localparam logic [D9_W-1:0] DIV9_MUL = D9_W'(59652324);

  // squared strength thresholds in q6.16
  localparam logic [DEV_W-1:0] STR_LIM0 = DEV_W'(655);
  localparam logic [DEV_W-1:0] STR_LIM1 = DEV_W'(2621);
  localparam logic [DEV_W-1:0] STR_LIM2 = DEV_W'(8028);
  localparam logic [DEV_W-1:0] STR_LIM3 = DEV_W'(16384);

  // strength classes
  localparam logic [STR_W-1:0] STR_VSTRONG  = 3'd0;
  localparam logic [STR_W-1:0] STR_STRONG   = 3'd1;
  localparam logic [STR_W-1:0] STR_MODERATE = 3'd2;
  localparam logic [STR_W-1:0] STR_WEAK     = 3'd3;
  localparam logic [STR_W-1:0] STR_NONE     = 3'd4;

  // output payload
  typedef struct packed {
    logic [TOT_W-1:0] total_items;
    logic [STR_W-1:0] strength;
    logic [DEV_W-1:0] deviation;
  } bfdt_result_t;

  // powers of ten up to 10^9
  function automatic logic [LIM_W-1:0] pow10(input logic [DIG_W-1:0] k);
    logic [LIM_W-1:0] p;
    unique case (k)
      4'd0:    p = LIM_W'(1);
      4'd1:    p = LIM_W'(10);
      4'd2:    p = LIM_W'(100);
      4'd3:    p = LIM_W'(1000);
      4'd4:    p = LIM_W'(10000);
      4'd5:    p = LIM_W'(100000);
      4'd6:    p = LIM_W'(1000000);
      4'd7:    p = LIM_W'(10000000);
      4'd8:    p = LIM_W'(100000000);
      4'd9:    p = LIM_W'(1000000000);
      default: p = LIM_W'(1000000000);
    endcase
    return p;
  endfunction

  // reciprocal of the expected proportion log10(1+1/d), q.16 rounded
  function automatic logic [RECIP_W-1:0] recip_q16(input logic [DIG_W-1:0] d);
    logic [RECIP_W-1:0] r;
    unique case (d)
      4'd1:    r = RECIP_W'(217706);
      4'd2:    r = RECIP_W'(372171);
      4'd3:    r = RECIP_W'(524545);
      4'd4:    r = RECIP_W'(676256);
      4'd5:    r = RECIP_W'(827674);
      4'd6:    r = RECIP_W'(978927);
      4'd7:    r = RECIP_W'(1130088);
      4'd8:    r = RECIP_W'(1281188);
      4'd9:    r = RECIP_W'(1432246);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/benford_first_digit_test.sv -----
// benford_first_digit_test: leading-digit histogram in a small digit store and the
// end-of-set variance pass; depends on bfdt_pkg
`timescale 1ns / 1ps
//
// Usage
//   in_*  : one value per transaction, in_tdata[30:0] holds the integer part,
//           in_tlast marks the final value of a data set
//   out_* : one result per data set, sent after the value marked last
// Sequencing
//   each value passes accept with decade compare, digit lookup with the
//   store read, and write back of the bin and the item total; a new value
//   is taken only once the last one is written back
//   after the last value a final pass runs over digits 1..9, each with read,
//   multiply, 22-step divider, error, square and accumulate, then the
//   division by 9 as a reciprocal multiply (skipped when the variance
//   saturates) and the output load, which waits for a free output
//   register; no input is taken during the pass
// Reset and stalls
//   rst_n clears the bin valid bits, the item total and the output valid,
//   so the store reads as all zero without a clearing pass; loading a
//   result clears the bin valid bits and the item total the same way
//   while a result waits for out_tready new values are still counted; the next
//   result waits until the output register is free, and no input is taken meanwhile

module benford_first_digit_test
  import bfdt_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // value input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] value_int, [31] zero fill
  input  logic        in_tlast,   // last
  // result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [21:0] deviation, [24:22] strength,
                                  // [48:25] total_items, [55:49] zero fill
);

  localparam int CB    = COUNT_BITS;
  localparam int DW    = CB + QW;
  localparam int PW    = CB + RECIP_W;
  localparam int CNT_W = $clog2(QW);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIG  = 4'd1;
  localparam logic [3:0] S_UPD  = 4'd2;
  localparam logic [3:0] S_FRD  = 4'd3;
  localparam logic [3:0] S_FMUL = 4'd4;
  localparam logic [3:0] S_FDIV = 4'd5;
  localparam logic [3:0] S_FERR = 4'd6;
  localparam logic [3:0] S_FSQ  = 4'd7;
  localparam logic [3:0] S_FACC = 4'd8;
  localparam logic [3:0] S_DDIV = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]       state_r, state_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             last_r, last_nxt;
  logic [DIG_W-1:0] dec_r, dec_nxt;
  logic [DIG_W-1:0] dig_r, dig_nxt;
  logic [DIG_W-1:0] d_r, d_nxt;
  logic [CB-1:0]    total_r, total_nxt;
  logic [DIGITS-1:0] valid_r, valid_nxt;

  // divider registers
  logic [CB-1:0]    rem_r, rem_nxt;
  logic [CB-1:0]    dvsr_r, dvsr_nxt;
  logic [QW-1:0]    dvd_r, dvd_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  // accumulation registers
  logic [ERR_W-1:0] err_r, err_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             dsat_r, dsat_nxt;

  // output register
  logic         out_tvalid_r, out_tvalid_nxt;
  bfdt_result_t res_r, res_nxt;

  // digit store
  logic [CB-1:0]    mem [DIGITS];
  logic [CB-1:0]    rdata_r;
  logic             rd_valid_r;
  logic [DIG_W-1:0] raddr;
  logic             mem_we;
  logic [CB-1:0]    wr_data;

  logic             in_acc;
  logic             out_free;
  logic [DIG_W-1:0] dec_c;
  logic [DIG_W-1:0] dig_c;
  logic [CB-1:0]    cnt_c;
  logic [PW-1:0]    prod_c;
  logic [DW-1:0]    prod_ext;
  logic [CB:0]      div_trial;
  logic [CB:0]      div_diff;
  logic             div_ge;
  logic             div_done;
  logic [D9_PW-1:0] div9_prod;
  logic [DEV_W-1:0] dev_c;
  logic [STR_W-1:0] str_c;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // decade of the incoming value
  always_comb begin
    dec_c = '0;
    for (int k = 1; k < DIGITS; k++) begin
      if (LIM_W'(in_tdata[VAL_W-1:0]) >= pow10(DIG_W'(k))) begin
        dec_c = dec_c + DIG_W'(1);
      end
    end
  end

  // leading digit within the stored decade
  always_comb begin
    dig_c = '0;
    for (int d = 1; d < DIGITS; d++) begin
      if (LIM_W'(val_r) >= LIM_W'(d) * pow10(dec_r)) begin
        dig_c = dig_c + DIG_W'(1);
      end
    end
  end

  // store read address: the item's digit or the final-pass digit
  assign raddr = (state_r == S_DIG) ? dig_c : d_r;

  // stored count, unwritten bins read as zero
  assign cnt_c    = rd_valid_r ? rdata_r : '0;
  assign prod_c   = PW'(cnt_c) * PW'(recip_q16(d_r));
  assign prod_ext = DW'(prod_c);

  // bin write back
  assign mem_we  = (state_r == S_UPD) && (dig_r != '0);
  assign wr_data = (cnt_c == '1) ? cnt_c : cnt_c + CB'(1);

  // one restoring divider step
  assign div_trial = {rem_r, dvd_r[QW-1]};
  assign div_ge    = div_trial >= {1'b0, dvsr_r};
  assign div_diff  = div_trial - {1'b0, dvsr_r};
  assign div_done  = (div_cnt_r == CNT_W'(QW - 1));

  // scaled sum times the reciprocal of 9; below the saturation limit it fits 26 bits
  assign div9_prod = D9_PW'(sum_r[16 +: D9_W]) * D9_PW'(DIV9_MUL);

  // variance and strength
  assign dev_c = dsat_r ? DEV_MAX : quo_r;
  always_comb begin
    if (dev_c < STR_LIM0) begin
      str_c = STR_VSTRONG;
    end else if (dev_c < STR_LIM1) begin
      str_c = STR_STRONG;
    end else if (dev_c < STR_LIM2) begin
      str_c = STR_MODERATE;
    end else if (dev_c < STR_LIM3) begin
      str_c = STR_WEAK;
    end else begin
      str_c = STR_NONE;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    val_nxt        = val_r;
    last_nxt       = last_r;
    dec_nxt        = dec_r;
    dig_nxt        = dig_r;
    d_nxt          = d_r;
    total_nxt      = total_r;
    valid_nxt      = valid_r;
    rem_nxt        = rem_r;
    dvsr_nxt       = dvsr_r;
    dvd_nxt        = dvd_r;
    quo_nxt        = quo_r;
    div_cnt_nxt    = div_cnt_r;
    err_nxt        = err_r;
    sq_nxt         = sq_r;
    sum_nxt        = sum_r;
    dsat_nxt       = dsat_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    // divider iterates while dividing by the item total
    if (state_r == S_FDIV) begin
      rem_nxt     = div_ge ? div_diff[CB-1:0] : div_trial[CB-1:0];
      dvd_nxt     = {dvd_r[QW-2:0], 1'b0};
      quo_nxt     = {quo_r[QW-2:0], div_ge};
      div_cnt_nxt = div_cnt_r + CNT_W'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          val_nxt   = in_tdata[VAL_W-1:0];
          last_nxt  = in_tlast;
          dec_nxt   = dec_c;
          state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        dig_nxt   = dig_c;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (dig_r != '0) begin
          valid_nxt[dig_r] = 1'b1;
        end
        total_nxt = (total_r == '1) ? total_r : total_r + CB'(1);
        if (last_r) begin
          d_nxt     = DIG_W'(1);
          sum_nxt   = '0;
          state_nxt = S_FRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FRD: begin
        state_nxt = S_FMUL;
      end
      S_FMUL: begin
        rem_nxt     = prod_ext[DW-1:QW];
        dvd_nxt     = prod_ext[QW-1:0];
        dvsr_nxt    = total_r;
        div_cnt_nxt = '0;
        state_nxt   = S_FDIV;
      end
      S_FDIV: begin
        if (div_done) begin
          state_nxt = S_FERR;
        end
      end
      S_FERR: begin
        err_nxt   = (quo_r >= ONE_Q16) ? ERR_W'(quo_r - ONE_Q16) : ERR_W'(ONE_Q16 - quo_r);
        state_nxt = S_FSQ;
      end
      S_FSQ: begin
        sq_nxt    = SQ_W'(err_r) * SQ_W'(err_r);
        state_nxt = S_FACC;
      end
      S_FACC: begin
        sum_nxt = sum_r + SUM_W'(sq_r);
        if (d_r == DIG_W'(DIGITS - 1)) begin
          // divide by 9 * 65536: drop 16 bits, then divide by 9 next cycle unless saturated
          dsat_nxt  = sum_nxt[SUM_W-1:16] >= DEV_SAT_LIM;
          state_nxt = dsat_nxt ? S_FIN : S_DDIV;
        end else begin
          d_nxt     = d_r + DIG_W'(1);
          state_nxt = S_FRD;
        end
      end
      S_DDIV: begin
        quo_nxt   = div9_prod[DIV9_SH +: QW];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          res_nxt.deviation   = dev_c;
          res_nxt.strength    = str_c;
          res_nxt.total_items = (33'(total_r) > TOTAL_MAX) ? TOT_W'(TOTAL_MAX)
                                                           : TOT_W'(total_r);
          out_tvalid_nxt = 1'b1;
          valid_nxt      = '0;
          total_nxt      = '0;
          dsat_nxt       = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      valid_r      <= '0;
      dsat_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      valid_r      <= valid_nxt;
      dsat_r       <= dsat_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    last_r    <= last_nxt;
    dec_r     <= dec_nxt;
    dig_r     <= dig_nxt;
    d_r       <= d_nxt;
    rem_r     <= rem_nxt;
    dvsr_r    <= dvsr_nxt;
    dvd_r     <= dvd_nxt;
    quo_r     <= quo_nxt;
    div_cnt_r <= div_cnt_nxt;
    err_r     <= err_nxt;
    sq_r      <= sq_nxt;
    sum_r     <= sum_nxt;
    res_r     <= res_nxt;
  end

  // digit store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[dig_r] <= wr_data;
    end
    rdata_r    <= mem[raddr];
    rd_valid_r <= valid_r[raddr];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, res_r};

  // bin zero is never written
  a_no_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (dig_r != '0) && (state_r == S_UPD))
    else $error("write to digit bin zero");

  // item total is nonzero after any update
  a_total_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |=> (total_r != '0))
    else $error("item total not counted");

  // result load clears the store
  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && out_free |=> (valid_r == '0) && (total_r == '0) && out_tvalid_r)
    else $error("store not cleared after result");

  // divider remainder stays below the divisor
  a_div_invariant: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FDIV) |-> (rem_r < dvsr_r))
    else $error("divider remainder out of range");

endmodule
